// ===== src/abm_pkg.sv =====
// abm_pkg: shared word types, request and error codes, queue sizing
// for the adjacency bit matrix block
// no dependencies
package abm_pkg;

    // field widths fixed by the request and result words
    localparam int NODE_W   = 4;
    localparam int REQ_W    = 3;
    localparam int COUNT_W  = 9;
    localparam int ERR_W    = 2;
    localparam int NCOUNT_W = 5;

    // configuration port
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam logic REG_NODE_COUNT = 1'b0;

    // saturation value of count_value
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // command queue between front and back (depth is a power of two)
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // request codes
    localparam logic [REQ_W-1:0] REQ_QUERY      = 3'd0;
    localparam logic [REQ_W-1:0] REQ_ADD        = 3'd1;
    localparam logic [REQ_W-1:0] REQ_REMOVE     = 3'd2;
    localparam logic [REQ_W-1:0] REQ_OUT_DEG    = 3'd3;
    localparam logic [REQ_W-1:0] REQ_IN_DEG     = 3'd4;
    localparam logic [REQ_W-1:0] REQ_DISCONNECT = 3'd5;
    localparam logic [REQ_W-1:0] REQ_EDGE_COUNT = 3'd6;

    // error codes
    localparam logic [ERR_W-1:0] ERR_OK     = 2'd0;
    localparam logic [ERR_W-1:0] ERR_RANGE  = 2'd1;
    localparam logic [ERR_W-1:0] ERR_ABSENT = 2'd2;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [NODE_W-1:0] node_a;
        logic [NODE_W-1:0] node_b;
    } req_word_t;

    typedef struct packed {
        logic               edge_present;
        logic [COUNT_W-1:0] count_value;
        logic [ERR_W-1:0]   error_code;
    } rsp_word_t;

    // classified operation handed from front to back
    typedef enum logic [2:0] {
        OP_QUERY,
        OP_ADD,
        OP_REMOVE,
        OP_OUT_DEG,
        OP_IN_DEG,
        OP_DISCONNECT,
        OP_EDGE_COUNT,
        OP_REPLY
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t           op;
        logic [NODE_W-1:0] node_a;
        logic [NODE_W-1:0] node_b;
        logic [ERR_W-1:0]  err;
    } cmd_t;

endpackage

// ===== src/abm_ram.sv =====
// abm_ram: generic simple dual-port ram with registered read
// one write port and one read port, no dependencies
module abm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/abm_front.sv =====
// abm_front: accepts request words and classifies them into commands
// range checks against the active node bound; uses abm_pkg
module abm_front
    import abm_pkg::*;
#(
    parameter int MAX_NODES = 16
) (
    input  logic                               in_valid,
    output logic                               in_ready,
    input  req_word_t                          in_word,
    input  logic [$clog2(MAX_NODES+1)-1:0]     bound,
    output logic                               push_valid,
    input  logic                               push_ready,
    output cmd_t                               push_cmd
);

    localparam int BND_W = $clog2(MAX_NODES + 1);
    localparam int CMP_W = BND_W + NODE_W;

    logic    a_ok;
    logic    b_ok;
    logic    need_a;
    logic    need_b;
    cmd_op_t op;

    // node range checks
    assign a_ok = CMP_W'(in_word.node_a) < CMP_W'(bound);
    assign b_ok = CMP_W'(in_word.node_b) < CMP_W'(bound);

    // decode request type
    always_comb
    begin
        need_a = 1'b0;
        need_b = 1'b0;
        op     = OP_REPLY;
        case (in_word.req_type)
            REQ_QUERY:
            begin
                op     = OP_QUERY;
                need_a = 1'b1;
                need_b = 1'b1;
            end
            REQ_ADD:
            begin
                op     = OP_ADD;
                need_a = 1'b1;
                need_b = 1'b1;
            end
            REQ_REMOVE:
            begin
                op     = OP_REMOVE;
                need_a = 1'b1;
                need_b = 1'b1;
            end
            REQ_OUT_DEG:
            begin
                op     = OP_OUT_DEG;
                need_a = 1'b1;
            end
            REQ_IN_DEG:
            begin
                op     = OP_IN_DEG;
                need_a = 1'b1;
            end
            REQ_DISCONNECT:
            begin
                op     = OP_DISCONNECT;
                need_a = 1'b1;
            end
            REQ_EDGE_COUNT:
            begin
                op = OP_EDGE_COUNT;
            end
            default:
            begin
                op = OP_REPLY;
            end
        endcase
    end

    // out-of-range nodes turn into an immediate error reply
    always_comb
    begin
        push_cmd.node_a = in_word.node_a;
        push_cmd.node_b = in_word.node_b;
        if ((need_a && !a_ok) || (need_b && !b_ok))
        begin
            push_cmd.op  = OP_REPLY;
            push_cmd.err = ERR_RANGE;
        end
        else
        begin
            push_cmd.op  = op;
            push_cmd.err = ERR_OK;
        end
    end

    assign push_valid = in_valid;
    assign in_ready   = push_ready;

endmodule

// ===== src/abm_queue.sv =====
// abm_queue: short command fifo between front and back
// uses abm_pkg for the command type and depth
module abm_queue
    import abm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  cmd_t push_cmd,
    output logic pop_valid,
    input  logic pop_ready,
    output cmd_t pop_cmd
);

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] fill_reg;
    logic [QCNT_W-1:0] fill_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = fill_reg != QCNT_W'(QUEUE_DEPTH);
    assign pop_valid  = fill_reg != '0;
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== src/abm_back.sv =====
// abm_back: executes commands against the row memory and holds the result word
// uses abm_pkg and abm_ram
module abm_back
    import abm_pkg::*;
#(
    parameter int MAX_NODES = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [$clog2(MAX_NODES+1)-1:0] bound,
    input  logic                           pop_valid,
    output logic                           pop_ready,
    input  cmd_t                           pop_cmd,
    output logic                           out_valid,
    input  logic                           out_ready,
    output rsp_word_t                      out_word
);

    localparam int IDX_W   = $clog2(MAX_NODES);
    localparam int BND_W   = $clog2(MAX_NODES + 1);
    localparam int ROWC_W  = $clog2(MAX_NODES + 1);
    localparam int TOT_W   = $clog2(MAX_NODES * MAX_NODES + 1);
    localparam int SAT_W   = (TOT_W > COUNT_W) ? TOT_W : COUNT_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_WALK,
        S_DONE
    } state_t;

    state_t                 state_reg;
    state_t                 state_next;
    cmd_t                   cmd_reg;
    cmd_t                   cmd_next;
    logic [IDX_W-1:0]       idx_reg;
    logic [IDX_W-1:0]       idx_next;
    logic [TOT_W-1:0]       cnt_reg;
    logic [TOT_W-1:0]       cnt_next;
    logic [TOT_W-1:0]       total_reg;
    logic [TOT_W-1:0]       total_next;
    logic [MAX_NODES-1:0]   row_valid_reg;
    logic [MAX_NODES-1:0]   row_valid_next;
    logic                   rd_valid_reg;
    logic                   rd_valid_next;
    rsp_word_t              res_reg;
    rsp_word_t              res_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    rsp_word_t              out_word_reg;
    rsp_word_t              out_word_next;

    logic                   wr_en;
    logic [IDX_W-1:0]       wr_addr;
    logic [MAX_NODES-1:0]   wr_data;
    logic                   rd_en;
    logic [IDX_W-1:0]       rd_addr;
    logic [MAX_NODES-1:0]   ram_q;
    logic [MAX_NODES-1:0]   row_data;
    logic [MAX_NODES-1:0]   mask;
    logic [MAX_NODES-1:0]   b_bit;
    logic [MAX_NODES-1:0]   a_bit;
    logic [IDX_W-1:0]       a_idx;
    logic [IDX_W-1:0]       b_idx;
    logic [TOT_W-1:0]       cnt_sum;
    logic                   walk_last;
    logic                   out_take;

    function automatic logic [IDX_W-1:0] node_idx(input logic [NODE_W-1:0] n);
        logic [IDX_W+NODE_W-1:0] w;
        w = (IDX_W + NODE_W)'(n);
        return w[IDX_W-1:0];
    endfunction

    function automatic logic [ROWC_W-1:0] pop_count(input logic [MAX_NODES-1:0] v);
        logic [ROWC_W-1:0] s;
        s = '0;
        for (int j = 0; j < MAX_NODES; j++)
        begin
            s = s + ROWC_W'(v[j]);
        end
        return s;
    endfunction

    function automatic logic [COUNT_W-1:0] sat_count(input logic [TOT_W-1:0] v);
        logic [SAT_W-1:0] w;
        w = SAT_W'(v);
        if (w > SAT_W'(COUNT_MAX))
        begin
            return COUNT_MAX;
        end
        return w[COUNT_W-1:0];
    endfunction

    // row memory
    abm_ram #(
        .WIDTH (MAX_NODES),
        .DEPTH (MAX_NODES)
    ) u_rows (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (ram_q)
    );

    // rows never written read as empty
    assign row_data = rd_valid_reg ? ram_q : '0;

    // columns below the active bound
    always_comb
    begin
        for (int j = 0; j < MAX_NODES; j++)
        begin
            mask[j] = BND_W'(j) < bound;
        end
    end

    assign a_idx     = node_idx(cmd_reg.node_a);
    assign b_idx     = node_idx(cmd_reg.node_b);
    assign a_bit     = MAX_NODES'(1) << a_idx;
    assign b_bit     = MAX_NODES'(1) << b_idx;
    assign walk_last = (BND_W'(idx_reg) + BND_W'(1)) >= bound;
    assign out_take  = out_valid_reg && out_ready;

    // per-row step of the in-degree and disconnect walks
    always_comb
    begin
        cnt_sum = cnt_reg;
        if (cmd_reg.op == OP_IN_DEG)
        begin
            cnt_sum = cnt_reg + TOT_W'(row_data[a_idx]);
        end
        else if (idx_reg == a_idx)
        begin
            cnt_sum = cnt_reg + TOT_W'(pop_count(row_data & mask));
        end
        else
        begin
            cnt_sum = cnt_reg + TOT_W'(row_data[a_idx]);
        end
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        total_next     = total_reg;
        res_next       = res_reg;
        out_valid_next = out_take ? 1'b0 : out_valid_reg;
        out_word_next  = out_word_reg;
        pop_ready      = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = a_idx;
        wr_en          = 1'b0;
        wr_addr        = a_idx;
        wr_data        = row_data;

        case (state_reg)
            S_IDLE:
            begin
                pop_ready = 1'b1;
                if (pop_valid)
                begin
                    cmd_next            = pop_cmd;
                    cnt_next            = '0;
                    idx_next            = '0;
                    res_next            = '0;
                    res_next.error_code = pop_cmd.err;
                    case (pop_cmd.op)
                        OP_QUERY, OP_ADD, OP_REMOVE, OP_OUT_DEG:
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = node_idx(pop_cmd.node_a);
                            state_next = S_READ;
                        end
                        OP_IN_DEG, OP_DISCONNECT:
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = '0;
                            state_next = S_WALK;
                        end
                        OP_EDGE_COUNT:
                        begin
                            res_next.count_value = sat_count(total_reg);
                            state_next           = S_DONE;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_READ:
            begin
                state_next = S_DONE;
                case (cmd_reg.op)
                    OP_QUERY:
                    begin
                        res_next.edge_present = row_data[b_idx];
                    end
                    OP_ADD:
                    begin
                        if (!row_data[b_idx])
                        begin
                            wr_en      = 1'b1;
                            wr_data    = row_data | b_bit;
                            total_next = total_reg + 1'b1;
                        end
                    end
                    OP_REMOVE:
                    begin
                        if (row_data[b_idx])
                        begin
                            wr_en      = 1'b1;
                            wr_data    = row_data & ~b_bit;
                            total_next = total_reg - 1'b1;
                        end
                        else
                        begin
                            res_next.error_code = ERR_ABSENT;
                        end
                    end
                    OP_OUT_DEG:
                    begin
                        res_next.count_value = sat_count(TOT_W'(pop_count(row_data & mask)));
                    end
                    default:
                    begin
                        res_next = res_reg;
                    end
                endcase
            end

            S_WALK:
            begin
                cnt_next = cnt_sum;
                // disconnect rewrites the current row while the next one is read
                if (cmd_reg.op == OP_DISCONNECT)
                begin
                    wr_en   = 1'b1;
                    wr_addr = idx_reg;
                    if (idx_reg == a_idx)
                    begin
                        wr_data = row_data & ~mask;
                    end
                    else
                    begin
                        wr_data = row_data & ~a_bit;
                    end
                end
                if (walk_last)
                begin
                    state_next = S_DONE;
                    if (cmd_reg.op == OP_DISCONNECT)
                    begin
                        total_next = total_reg - cnt_sum;
                    end
                    else
                    begin
                        res_next.count_value = sat_count(cnt_sum);
                    end
                end
                else
                begin
                    rd_en    = 1'b1;
                    rd_addr  = idx_reg + 1'b1;
                    idx_next = idx_reg + 1'b1;
                end
            end

            S_DONE:
            begin
                if (!out_valid_reg || out_take)
                begin
                    out_word_next  = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // row valid bits follow the writes, read valid follows the reads
    always_comb
    begin
        row_valid_next = row_valid_reg;
        if (wr_en)
        begin
            row_valid_next[wr_addr] = 1'b1;
        end
        rd_valid_next = rd_en ? row_valid_reg[rd_addr] : rd_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cmd_reg       <= '0;
            idx_reg       <= '0;
            cnt_reg       <= '0;
            total_reg     <= '0;
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
            res_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_word_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cmd_reg       <= cmd_next;
            idx_reg       <= idx_next;
            cnt_reg       <= cnt_next;
            total_reg     <= total_next;
            row_valid_reg <= row_valid_next;
            rd_valid_reg  <= rd_valid_next;
            res_reg       <= res_next;
            out_valid_reg <= out_valid_next;
            out_word_reg  <= out_word_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

// ===== src/adjacency_bit_matrix_top.sv =====
// Directed-graph adjacency matrix of single-bit entries for up to MAX_NODES
// nodes, cleared at reset. A request word names an operation (query, add,
// remove, out-degree, in-degree, disconnect, edge count) and one or two
// nodes; each request gives exactly one result word. Nodes at or above the
// active bound, min(node_count, MAX_NODES), are answered with a range error.
// Requests are classified and queued in front of an execution unit, so up to
// two requests are taken while one is being worked on. The execution unit
// handles one request at a time: edge count and errors need no row read,
// query, add, remove and out-degree need one row read, and in-degree and
// disconnect walk the row memory one row per cycle through its single read
// port. The result word sits in an output register while the next request
// starts. No clearing pass is needed after reset: per-row valid bits make
// unwritten rows read as empty.
// top level: uses abm_pkg, abm_front, abm_queue, abm_back, abm_ram
module adjacency_bit_matrix_top
    import abm_pkg::*;
#(
    parameter int MAX_NODES = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  req_word_t         in_word,
    output logic              out_valid,
    input  logic              out_ready,
    output rsp_word_t         out_word,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    localparam int BND_W = $clog2(MAX_NODES + 1);
    localparam int CMP_W = (BND_W > NCOUNT_W) ? BND_W : NCOUNT_W;

    logic [NCOUNT_W-1:0] node_count_reg;
    logic [NCOUNT_W-1:0] node_count_next;
    logic [BND_W-1:0]    bound;
    logic                push_valid;
    logic                push_ready;
    cmd_t                push_cmd;
    logic                pop_valid;
    logic                pop_ready;
    cmd_t                pop_cmd;
    logic                reg_sel;

    // configuration register
    assign pready  = 1'b1;
    assign reg_sel = paddr[ADDR_W-1] == REG_NODE_COUNT;

    always_comb
    begin
        node_count_next = node_count_reg;
        if (psel && penable && pwrite && reg_sel)
        begin
            node_count_next = pwdata[NCOUNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= '0;
        end
        else
        begin
            node_count_reg <= node_count_next;
        end
    end

    assign prdata = reg_sel ? DATA_W'(node_count_reg) : '0;

    // active node bound
    assign bound = (CMP_W'(node_count_reg) > CMP_W'(MAX_NODES))
                   ? BND_W'(MAX_NODES) : BND_W'(node_count_reg);

    abm_front #(
        .MAX_NODES (MAX_NODES)
    ) u_front (
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_word    (in_word),
        .bound      (bound),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    abm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    abm_back #(
        .MAX_NODES (MAX_NODES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .bound     (bound),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_cmd   (pop_cmd),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word)
    );

endmodule

// ===== tb/tb_adjacency_bit_matrix_top.sv =====
// tb_adjacency_bit_matrix_top: self-checking bench for the adjacency bit matrix,
// with a matrix predictor class and directed then random request words
// depends on abm_pkg and adjacency_bit_matrix_top
import abm_pkg::*;

localparam int GRAPH_NODES = 16;

// predicts each result word from its own copy of the matrix, checks in order
class matrix_scoreboard;
    logic [GRAPH_NODES-1:0] rows [GRAPH_NODES];
    int unsigned            edge_total;
    logic [NCOUNT_W-1:0]    node_count;
    rsp_word_t              pending_q [$];
    int unsigned            errors;
    int unsigned            checked;
    int unsigned            kind_seen [8];

    function new();
        foreach (rows[i])
            rows[i] = '0;
        foreach (kind_seen[i])
            kind_seen[i] = 0;
        edge_total = 0;
        node_count = '0;
        errors     = 0;
        checked    = 0;
    endfunction

    function void flag(string msg);
        errors++;
        if (errors <= 10)
            $display("mismatch: %s", msg);
    endfunction

    function int unsigned pending();
        return pending_q.size();
    endfunction

    function int unsigned active_bound();
        return (node_count > GRAPH_NODES) ? GRAPH_NODES : node_count;
    endfunction

    function logic [COUNT_W-1:0] clip_count(int unsigned n);
        return (n > COUNT_MAX) ? COUNT_MAX : COUNT_W'(n);
    endfunction

    // apply one accepted request word to the matrix and queue its result word
    function void note_request(req_word_t w);
        rsp_word_t              res;
        int unsigned            bound;
        logic [GRAPH_NODES-1:0] mask;
        bit                     a_ok;
        bit                     b_ok;
        int unsigned            n;
        int unsigned            i;
        res   = '0;
        bound = active_bound();
        mask  = '0;
        for (i = 0; i < bound; i++)
            mask[i] = 1'b1;
        a_ok = w.node_a < bound;
        b_ok = w.node_b < bound;
        n    = 0;
        case (w.req_type)
            REQ_QUERY: begin
                if (a_ok && b_ok)
                    res.edge_present = rows[w.node_a][w.node_b];
                else
                    res.error_code = ERR_RANGE;
            end
            REQ_ADD: begin
                if (!(a_ok && b_ok))
                    res.error_code = ERR_RANGE;
                else if (!rows[w.node_a][w.node_b])
                begin
                    rows[w.node_a][w.node_b] = 1'b1;
                    edge_total++;
                end
            end
            REQ_REMOVE: begin
                if (!(a_ok && b_ok))
                    res.error_code = ERR_RANGE;
                else if (!rows[w.node_a][w.node_b])
                    res.error_code = ERR_ABSENT;
                else
                begin
                    rows[w.node_a][w.node_b] = 1'b0;
                    edge_total--;
                end
            end
            REQ_OUT_DEG: begin
                if (a_ok)
                    res.count_value = clip_count($countones(rows[w.node_a] & mask));
                else
                    res.error_code = ERR_RANGE;
            end
            REQ_IN_DEG: begin
                if (a_ok)
                begin
                    for (i = 0; i < bound; i++)
                        n += rows[i][w.node_a];
                    res.count_value = clip_count(n);
                end
                else
                    res.error_code = ERR_RANGE;
            end
            REQ_DISCONNECT: begin
                // a self loop goes with the row and is not seen again in the column
                if (a_ok)
                begin
                    n = $countones(rows[w.node_a] & mask);
                    rows[w.node_a] &= ~mask;
                    for (i = 0; i < bound; i++)
                    begin
                        if (rows[i][w.node_a])
                        begin
                            rows[i][w.node_a] = 1'b0;
                            n++;
                        end
                    end
                    edge_total -= n;
                end
                else
                    res.error_code = ERR_RANGE;
            end
            REQ_EDGE_COUNT: res.count_value = clip_count(edge_total);
            default: ;
        endcase
        kind_seen[w.req_type]++;
        pending_q.push_back(res);
    endfunction

    // compare one result word with the oldest prediction
    function void check_result(rsp_word_t got);
        rsp_word_t want;
        checked++;
        if (pending_q.size() == 0)
        begin
            flag($sformatf("result word %0d (0x%h) with no request outstanding",
                           checked, got));
            return;
        end
        want = pending_q.pop_front();
        if (got.edge_present !== want.edge_present || got.count_value !== want.count_value
            || got.error_code !== want.error_code)
            flag($sformatf({"word %0d: expected present=%0b count=%0d err=%0d, ",
                            "got present=%0b count=%0d err=%0d"}, checked,
                           want.edge_present, want.count_value, want.error_code,
                           got.edge_present, got.count_value, got.error_code));
    endfunction

    function void close();
        if (pending_q.size() != 0)
            flag($sformatf("%0d result words never arrived", pending_q.size()));
    endfunction
endclass

module tb_adjacency_bit_matrix_top;

    localparam int unsigned      LIMIT      = 800000;
    localparam int unsigned      PHASE_LEN  = 110;
    localparam logic [REQ_W-1:0] REQ_UNUSED = 3'd7;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    req_word_t         in_word;
    logic              out_valid;
    logic              out_ready;
    rsp_word_t         out_word;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    matrix_scoreboard sb = new();
    bit               no_idle = 1'b0;
    int unsigned      cycles = 0;
    int unsigned      settings_used = 0;

    adjacency_bit_matrix_top #(
        .MAX_NODES (GRAPH_NODES)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("run stopped after %0d cycles", cycles);
            $display("tb_adjacency_bit_matrix_top: errors");
            $finish;
        end
    end

    // watch both handshakes at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            sb.note_request(in_word);
        if (rst_n && out_valid && out_ready)
            sb.check_result(out_word);
    end

    // mostly short gaps, a few long ones
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [NODE_W-1:0] pick_node(int unsigned bound);
        if (bound != 0 && $urandom_range(0, 9) < 8)
            return NODE_W'($urandom_range(0, bound - 1));
        return NODE_W'($urandom_range(0, 15));
    endfunction

    // adds dominate so the matrix fills up before removes and disconnects
    function automatic req_word_t random_item(int unsigned bound);
        req_word_t   w;
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 30)
            w.req_type = REQ_ADD;
        else if (r < 45)
            w.req_type = REQ_REMOVE;
        else if (r < 60)
            w.req_type = REQ_QUERY;
        else if (r < 70)
            w.req_type = REQ_OUT_DEG;
        else if (r < 80)
            w.req_type = REQ_IN_DEG;
        else if (r < 86)
            w.req_type = REQ_DISCONNECT;
        else if (r < 96)
            w.req_type = REQ_EDGE_COUNT;
        else
            w.req_type = REQ_UNUSED;
        w.node_a = pick_node(bound);
        w.node_b = pick_node(bound);
        return w;
    endfunction

    // offer one request word, return at the edge where it is taken
    task automatic send_req(input logic [REQ_W-1:0] kind, input logic [NODE_W-1:0] a,
                            input logic [NODE_W-1:0] b);
        int unsigned gap;
        gap = no_idle ? 0 : pick_gap();
        @(negedge clk);
        if (gap != 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid         = 1'b1;
        in_word.req_type = kind;
        in_word.node_a   = a;
        in_word.node_b   = b;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // stop sending and wait for every outstanding result word
    task automatic wait_drained();
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    // node_count write, only with the block idle
    task automatic write_node_count(input logic [NCOUNT_W-1:0] value);
        wait_drained();
        @(negedge clk);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = ADDR_W'({REG_NODE_COUNT, 2'b00});
        pwdata  = DATA_W'(value);
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        sb.node_count = value;
        settings_used++;
    endtask

    // result side back-pressure
    initial
    begin : ready_driver
        int unsigned stall_left;
        stall_left = 0;
        out_ready  = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (stall_left != 0)
            begin
                out_ready = 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready = 1'b1;
                if (!no_idle && $urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    // stimulus
    initial
    begin : stimulus
        logic [NCOUNT_W-1:0] settings [12];
        req_word_t           w;
        int unsigned         p;
        int unsigned         k;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_word   = '0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        settings  = '{5'd16, 5'd5, 5'd31, 5'd1, 5'd16, 5'd2, 5'd0, 5'd17, 5'd11, 5'd16,
                      5'd3, 5'd8};
        settings[8] = NCOUNT_W'($urandom_range(0, 31));
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset bound is zero: every node is out of range
        send_req(REQ_QUERY, 4'd0, 4'd15);
        send_req(REQ_EDGE_COUNT, 4'd0, 4'd0);

        // full bound: extreme nodes, self loop, duplicate add, absent remove
        write_node_count(5'd16);
        send_req(REQ_ADD, 4'd0, 4'd15);
        send_req(REQ_ADD, 4'd15, 4'd0);
        send_req(REQ_ADD, 4'd15, 4'd15);
        send_req(REQ_ADD, 4'd0, 4'd15);
        send_req(REQ_QUERY, 4'd0, 4'd15);
        send_req(REQ_QUERY, 4'd7, 4'd7);
        send_req(REQ_REMOVE, 4'd3, 4'd4);
        send_req(REQ_OUT_DEG, 4'd15, 4'd0);
        send_req(REQ_IN_DEG, 4'd15, 4'd0);
        send_req(REQ_EDGE_COUNT, 4'd0, 4'd0);
        send_req(REQ_UNUSED, 4'd15, 4'd15);
        send_req(REQ_DISCONNECT, 4'd15, 4'd9);
        send_req(REQ_EDGE_COUNT, 4'd0, 4'd0);
        send_req(REQ_ADD, 4'd5, 4'd6);
        send_req(REQ_REMOVE, 4'd5, 4'd6);
        send_req(REQ_QUERY, 4'd5, 4'd6);
        send_req(REQ_ADD, 4'd3, 4'd3);
        send_req(REQ_ADD, 4'd9, 4'd3);

        // lowered bound hides node 9 but keeps its edge in the total
        write_node_count(5'd4);
        send_req(REQ_ADD, 4'd3, 4'd3);
        send_req(REQ_ADD, 4'd4, 4'd0);
        send_req(REQ_QUERY, 4'd0, 4'd5);
        send_req(REQ_IN_DEG, 4'd3, 4'd0);
        send_req(REQ_OUT_DEG, 4'd9, 4'd0);
        send_req(REQ_EDGE_COUNT, 4'd0, 4'd0);

        // bound above the matrix size acts as the full matrix
        write_node_count(5'd31);
        send_req(REQ_IN_DEG, 4'd3, 4'd0);

        // random phases over several bounds
        for (p = 0; p < 12; p++)
        begin
            write_node_count(settings[p]);
            no_idle = (p % 6 == 3);
            for (k = 0; k < PHASE_LEN; k++)
            begin
                if (k == PHASE_LEN / 2 || $urandom_range(0, 99) == 0)
                    wait_drained();
                w = random_item(sb.active_bound());
                send_req(w.req_type, w.node_a, w.node_b);
            end
        end
        no_idle = 1'b0;

        wait_drained();
        repeat (40) @(negedge clk);
        sb.close();
        $display("covered %0d requests: query %0d, add %0d, remove %0d, out-degree %0d,",
                 sb.kind_seen.sum(), sb.kind_seen[REQ_QUERY], sb.kind_seen[REQ_ADD],
                 sb.kind_seen[REQ_REMOVE], sb.kind_seen[REQ_OUT_DEG]);
        $display("in-degree %0d, disconnect %0d, edge count %0d, unused code %0d; %0d bounds",
                 sb.kind_seen[REQ_IN_DEG], sb.kind_seen[REQ_DISCONNECT],
                 sb.kind_seen[REQ_EDGE_COUNT], sb.kind_seen[REQ_UNUSED], settings_used);
        if (sb.errors == 0)
            $display("tb_adjacency_bit_matrix_top: clean");
        else
            $display("tb_adjacency_bit_matrix_top: errors");
        $finish;
    end

endmodule
